// File: rtl/core/button_gesture_classifier_defines.svh
// Assertion macros shared by the button gesture classifier RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BGC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgc assertion failed");

`endif

// File: rtl/core/bgc_pkg.sv
// Package for the button gesture classifier: event codes, register map,
// configuration struct and the signed time compare helpers. No dependencies.
package bgc_pkg;

    localparam int unsigned CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_DBL_WIN   = 3'd1,
        REG_LONG      = 3'd2,
        REG_VERY_LONG = 3'd3,
        REG_IDLE_LVL  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_CLICK     = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_LONG      = 3'd3,
        EV_VERY_LONG = 3'd4
    } t_event;

    localparam logic [15:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [15:0] DBL_WIN_RST   = 16'd250;
    localparam logic [15:0] LONG_RST      = 16'd1000;
    localparam logic [15:0] VERY_LONG_RST = 16'd6000;
    localparam logic        IDLE_LVL_RST  = 1'b1;
    localparam logic [31:0] TIME_RST      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] double_click_window_ms;
        logic [15:0] long_press_ms;
        logic [15:0] very_long_press_ms;
        logic        idle_level;
    } t_cfg;

    // The difference d is a wrapping signed 32-bit value; thresholds are unsigned.
    function automatic logic time_gt(input logic [31:0] d, input logic [15:0] thr);
        return !d[31] && (d[30:0] > {15'd0, thr});
    endfunction

    function automatic logic time_ge(input logic [31:0] d, input logic [15:0] thr);
        return !d[31] && (d[30:0] >= {15'd0, thr});
    endfunction

    function automatic logic time_lt(input logic [31:0] d, input logic [15:0] thr);
        return d[31] || (d[30:0] < {15'd0, thr});
    endfunction

endpackage

// File: rtl/core/bgc_sample_if.sv
// Input channel of the button gesture classifier: one raw level sample
// with its millisecond timestamp per item. No dependencies.
interface bgc_sample_if;
    logic        valid;
    logic        ready;
    logic        button_level;
    logic [31:0] now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

// File: rtl/core/bgc_event_if.sv
// Output channel of the button gesture classifier: one event code per item.
// No dependencies.
interface bgc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

// File: rtl/core/bgc_regs.sv
// APB-style configuration registers of the button gesture classifier.
// Depends on bgc_pkg for the register map, reset values and t_cfg.
module bgc_regs
    import bgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms            <= DEBOUNCE_RST;
            r_cfg.double_click_window_ms <= DBL_WIN_RST;
            r_cfg.long_press_ms          <= LONG_RST;
            r_cfg.very_long_press_ms     <= VERY_LONG_RST;
            r_cfg.idle_level             <= IDLE_LVL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEBOUNCE:  r_cfg.debounce_ms            <= pwdata[15:0];
                REG_DBL_WIN:   r_cfg.double_click_window_ms <= pwdata[15:0];
                REG_LONG:      r_cfg.long_press_ms          <= pwdata[15:0];
                REG_VERY_LONG: r_cfg.very_long_press_ms     <= pwdata[15:0];
                REG_IDLE_LVL:  r_cfg.idle_level             <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DEBOUNCE:  prdata = {16'd0, r_cfg.debounce_ms};
            REG_DBL_WIN:   prdata = {16'd0, r_cfg.double_click_window_ms};
            REG_LONG:      prdata = {16'd0, r_cfg.long_press_ms};
            REG_VERY_LONG: prdata = {16'd0, r_cfg.very_long_press_ms};
            REG_IDLE_LVL:  prdata = {31'd0, r_cfg.idle_level};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/bgc_step.sv
// Gesture state registers and the single-pass classification logic.
// Depends on bgc_pkg and on the assertion macros in the defines header.
`include "button_gesture_classifier_defines.svh"

module bgc_step
    import bgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_level,
    input  logic [31:0] i_now,
    input  t_cfg        i_cfg,
    output logic [2:0]  o_event_code
);

    logic        r_prev, n_prev;
    logic [31:0] r_prs, n_prs;
    logic [31:0] r_rel, n_rel;
    logic        r_click, n_click;
    logic        r_dbl, n_dbl;
    logic        r_single, n_single;
    logic        r_skip, n_skip;
    logic        r_hold, n_hold;

    logic        w_pressed;
    logic        w_was;
    logic [31:0] w_d_rel;
    logic [31:0] w_d_prs;
    logic [31:0] w_d_rel2;
    logic [31:0] w_held;
    logic        w_rel_zero;
    logic        w_prs_zero;
    t_event      w_ev;

    assign w_pressed = i_level != i_cfg.idle_level;
    assign w_was     = r_prev != i_cfg.idle_level;
    assign w_d_rel   = i_now - r_rel;
    assign w_d_prs   = i_now - r_prs;

    always_comb begin
        n_prev     = i_level;
        n_prs      = r_prs;
        n_rel      = r_rel;
        n_click    = r_click;
        n_dbl      = r_dbl;
        n_single   = r_single;
        n_skip     = r_skip;
        n_hold     = r_hold;
        w_ev       = EV_NONE;
        w_rel_zero = 1'b0;
        w_prs_zero = 1'b0;

        if (w_pressed && !w_was && time_gt(w_d_rel, i_cfg.debounce_ms)) begin
            n_prs      = i_now;
            w_prs_zero = 1'b1;
            n_skip     = 1'b0;
            n_single   = 1'b1;
            n_hold     = 1'b0;
            n_dbl      = time_lt(w_d_rel, i_cfg.double_click_window_ms) && !r_dbl && r_click;
            n_click    = 1'b0;
        end else if (!w_pressed && w_was && time_gt(w_d_prs, i_cfg.debounce_ms)) begin
            if (!r_skip) begin
                n_rel      = i_now;
                w_rel_zero = 1'b1;
                if (!r_dbl) begin
                    n_click = 1'b1;
                end else begin
                    w_ev     = EV_DOUBLE;
                    n_dbl    = 1'b0;
                    n_click  = 1'b0;
                    n_single = 1'b0;
                end
            end
        end

        w_d_rel2 = w_rel_zero ? 32'd0 : w_d_rel;
        if (!w_pressed && time_ge(w_d_rel2, i_cfg.double_click_window_ms) && n_click
                && !n_dbl && n_single && (w_ev != EV_DOUBLE)) begin
            w_ev    = EV_CLICK;
            n_click = 1'b0;
        end

        w_held = w_prs_zero ? 32'd0 : w_d_prs;
        if (!w_pressed && w_was && time_ge(w_held, i_cfg.long_press_ms)
                && time_lt(w_held, i_cfg.very_long_press_ms) && !n_hold) begin
            w_ev    = EV_LONG;
            n_skip  = 1'b1;
            n_dbl   = 1'b0;
            n_click = 1'b0;
            n_hold  = 1'b1;
        end
        if (w_pressed && time_ge(w_held, i_cfg.very_long_press_ms) && !n_hold) begin
            w_ev    = EV_VERY_LONG;
            n_skip  = 1'b1;
            n_dbl   = 1'b0;
            n_click = 1'b0;
            n_hold  = 1'b1;
        end
    end

    assign o_event_code = w_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b1;
            r_prs    <= TIME_RST;
            r_rel    <= TIME_RST;
            r_click  <= 1'b0;
            r_dbl    <= 1'b0;
            r_single <= 1'b0;
            r_skip   <= 1'b0;
            r_hold   <= 1'b0;
        end else if (i_en) begin
            r_prev   <= n_prev;
            r_prs    <= n_prs;
            r_rel    <= n_rel;
            r_click  <= n_click;
            r_dbl    <= n_dbl;
            r_single <= n_single;
            r_skip   <= n_skip;
            r_hold   <= n_hold;
        end
    end

    // A hold event marks the press as reported and blocks its release.
    `BGC_ASSERT_NEXT(a_hold_marks, i_clk, i_rst_n, i_en && (w_ev == EV_LONG || w_ev == EV_VERY_LONG), r_hold && r_skip && !r_click)
    // A double click needs the armed flag from the second press.
    `BGC_ASSERT_IMPL(a_double_armed, i_clk, i_rst_n, i_en && w_ev == EV_DOUBLE, r_dbl && !r_skip)
    // A reported click clears the pending click.
    `BGC_ASSERT_NEXT(a_click_clears, i_clk, i_rst_n, i_en && w_ev == EV_CLICK, !r_click)

endmodule

// File: rtl/core/button_gesture_classifier.sv
// Button gesture classifier top level: input register, classification step, result register.
// An accepted item passes the input register and bgc_step into the result register.
// Throughput: one item per cycle while o_event.ready does not stall the output.
// Reset (synchronous, active low) empties both registers, restores the gesture
// state and loads the register defaults; no clearing pass is needed.
module button_gesture_classifier
    import bgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bgc_sample_if.sink            i_sample,
    bgc_event_if.source           o_event,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg        w_cfg;
    logic        r_in_valid;
    logic        r_in_level;
    logic [31:0] r_in_now;
    logic        r_out_valid;
    logic [2:0]  r_out_code;
    logic        w_advance;
    logic        w_step_en;
    logic [2:0]  w_code;

    bgc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance      = !r_out_valid || o_event.ready;
    assign w_step_en      = r_in_valid && w_advance;
    assign i_sample.ready = !r_in_valid || w_advance;

    bgc_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_step_en),
        .i_level      (r_in_level),
        .i_now        (r_in_now),
        .i_cfg        (w_cfg),
        .o_event_code (w_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_level <= i_sample.button_level;
            r_in_now   <= i_sample.now_ms;
        end
        if (w_step_en) begin
            r_out_code <= w_code;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_code = r_out_code;

endmodule
